// ===== rtl/branch_condition_unit_macros.svh =====
// Assertion macros shared by the checker of the branch condition unit.
// Every macro samples on the rising edge of clk and reports by $error.
`ifndef BRANCH_CONDITION_UNIT_MACROS_SVH
`define BRANCH_CONDITION_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define BCU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define BCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BCU_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcu_pkg
// Types and constants shared by the branch condition unit: condition codes,
// register write kinds, status codes, cycle charges and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bcu_pkg;

  // The sixteen standard condition codes, opcode bits 11..8.
  typedef enum logic [3:0] {
    COND_T  = 4'h0,
    COND_F  = 4'h1,
    COND_HI = 4'h2,
    COND_LS = 4'h3,
    COND_CC = 4'h4,
    COND_CS = 4'h5,
    COND_NE = 4'h6,
    COND_EQ = 4'h7,
    COND_VC = 4'h8,
    COND_VS = 4'h9,
    COND_PL = 4'hA,
    COND_MI = 4'hB,
    COND_GE = 4'hC,
    COND_LT = 4'hD,
    COND_GT = 4'hE,
    COND_LE = 4'hF
  } cond_t;

  // Opcode line codes, opcode bits 15..12.
  localparam logic [3:0] LINE_QUICK  = 4'h5;
  localparam logic [3:0] LINE_BRANCH = 4'h6;

  // Size field value that marks DBcc and Scc, and their mode fields.
  localparam logic [1:0] SIZE_SCC    = 2'b11;
  localparam logic [2:0] MODE_DREG   = 3'd0;
  localparam logic [2:0] MODE_DBCC   = 3'd1;

  // Register write kinds.
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_WORD = 2'd1;
  localparam logic [1:0] WK_BYTE = 2'd2;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;

  // Clock cycles charged per instruction outcome.
  localparam logic [4:0] CYC_BRANCH      = 5'd10;
  localparam logic [4:0] CYC_BSR         = 5'd18;
  localparam logic [4:0] CYC_BCC_WORD_NT = 5'd12;
  localparam logic [4:0] CYC_BCC_BYTE_NT = 5'd8;
  localparam logic [4:0] CYC_DB_EXPIRED  = 5'd14;
  localparam logic [4:0] CYC_SCC_TRUE    = 5'd6;
  localparam logic [4:0] CYC_SCC_FALSE   = 5'd4;

  // Scc byte values.
  localparam logic [15:0] SCC_SET   = 16'h00FF;
  localparam logic [15:0] SCC_CLEAR = 16'h0000;

  // DBcc counter value that ends the loop.
  localparam logic [15:0] COUNT_EXPIRED = 16'hFFFF;

  // One result record.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        push_return;
    logic [31:0] return_addr;
    logic [2:0]  dest_reg;
    logic [1:0]  reg_write_kind;
    logic [15:0] reg_value;
    logic [4:0]  cycles;
    logic        uses_ext;
    logic        status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bcu_cond.sv =====
// ----------------------------------------------------------------------------
// bcu_cond
// Evaluates one of the sixteen standard conditions against N, Z, V and C.
// ----------------------------------------------------------------------------
`default_nettype none

module bcu_cond (
  input  wire bcu_pkg::cond_t cond,
  input  wire logic [3:0]     nzvc,
  output logic                cond_ok
);

  logic n, z, v, c;

  assign n = nzvc[3];
  assign z = nzvc[2];
  assign v = nzvc[1];
  assign c = nzvc[0];

  // Condition decoder.
  always_comb begin
    unique case (cond)
      bcu_pkg::COND_T:  cond_ok = 1'b1;
      bcu_pkg::COND_F:  cond_ok = 1'b0;
      bcu_pkg::COND_HI: cond_ok = !c && !z;
      bcu_pkg::COND_LS: cond_ok = c || z;
      bcu_pkg::COND_CC: cond_ok = !c;
      bcu_pkg::COND_CS: cond_ok = c;
      bcu_pkg::COND_NE: cond_ok = !z;
      bcu_pkg::COND_EQ: cond_ok = z;
      bcu_pkg::COND_VC: cond_ok = !v;
      bcu_pkg::COND_VS: cond_ok = v;
      bcu_pkg::COND_PL: cond_ok = !n;
      bcu_pkg::COND_MI: cond_ok = n;
      bcu_pkg::COND_GE: cond_ok = (n == v);
      bcu_pkg::COND_LT: cond_ok = (n != v);
      bcu_pkg::COND_GT: cond_ok = !z && (n == v);
      bcu_pkg::COND_LE: cond_ok = z || (n != v);
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bcu_exec.sv =====
// ----------------------------------------------------------------------------
// bcu_exec
// Decodes one instruction word and works out its result record: target and
// fall-through addresses, BSR return address, DBcc/Scc register write and
// cycle charge.
// ----------------------------------------------------------------------------
`default_nettype none

module bcu_exec (
  input  wire logic [15:0]   opcode,
  input  wire logic [31:0]   instr_pc,
  input  wire logic [15:0]   ext_word,
  input  wire logic [3:0]    nzvc,
  input  wire logic [15:0]   count_in,
  output bcu_pkg::res_t      res
);

  bcu_pkg::cond_t cond;
  logic           cond_ok;
  logic           is_bcc;
  logic           is_dbcc;
  logic           is_scc;
  logic           short_disp;
  logic [31:0]    disp;
  logic [31:0]    target;
  logic [31:0]    pc_plus2;
  logic [15:0]    count_dec;
  logic           go;

  assign cond = bcu_pkg::cond_t'(opcode[11:8]);

  bcu_cond u_cond (
    .cond    (cond),
    .nzvc    (nzvc),
    .cond_ok (cond_ok)
  );

  // Instruction class decode.
  assign is_bcc  = (opcode[15:12] == bcu_pkg::LINE_BRANCH);
  assign is_dbcc = (opcode[15:12] == bcu_pkg::LINE_QUICK) &&
                   (opcode[7:6] == bcu_pkg::SIZE_SCC) &&
                   (opcode[5:3] == bcu_pkg::MODE_DBCC);
  assign is_scc  = (opcode[15:12] == bcu_pkg::LINE_QUICK) &&
                   (opcode[7:6] == bcu_pkg::SIZE_SCC) &&
                   (opcode[5:3] == bcu_pkg::MODE_DREG);

  // A non-zero low byte is a short displacement; otherwise the word follows.
  assign short_disp = is_bcc && (opcode[7:0] != 8'h00);
  assign disp       = short_disp ? {{24{opcode[7]}}, opcode[7:0]}
                                 : {{16{ext_word[15]}}, ext_word};
  assign target     = instr_pc + disp;
  assign pc_plus2   = instr_pc + 32'd2;
  assign count_dec  = count_in - 16'd1;

  // BRA and BSR always go; the other branches follow the condition.
  assign go = cond_ok || (cond == bcu_pkg::COND_F);

  // Result record.
  always_comb begin
    res                = '0;
    res.next_pc        = instr_pc;
    res.reg_write_kind = bcu_pkg::WK_NONE;
    res.status         = bcu_pkg::STATUS_OK;
    if (is_bcc) begin
      res.uses_ext = !short_disp;
      if (cond == bcu_pkg::COND_F) begin
        res.push_return = 1'b1;
        res.return_addr = short_disp ? instr_pc : pc_plus2;
        res.cycles      = bcu_pkg::CYC_BSR;
      end else if (go) begin
        res.cycles = bcu_pkg::CYC_BRANCH;
      end else begin
        res.cycles = short_disp ? bcu_pkg::CYC_BCC_BYTE_NT : bcu_pkg::CYC_BCC_WORD_NT;
      end
      if (go) begin
        res.branch_taken = 1'b1;
        res.next_pc      = target;
      end else begin
        res.next_pc = short_disp ? instr_pc : pc_plus2;
      end
    end else if (is_dbcc) begin
      res.uses_ext = 1'b1;
      if (cond_ok) begin
        res.next_pc = pc_plus2;
        res.cycles  = bcu_pkg::CYC_BCC_WORD_NT;
      end else begin
        res.dest_reg       = opcode[2:0];
        res.reg_write_kind = bcu_pkg::WK_WORD;
        res.reg_value      = count_dec;
        if (count_dec != bcu_pkg::COUNT_EXPIRED) begin
          res.branch_taken = 1'b1;
          res.next_pc      = target;
          res.cycles       = bcu_pkg::CYC_BRANCH;
        end else begin
          res.next_pc = pc_plus2;
          res.cycles  = bcu_pkg::CYC_DB_EXPIRED;
        end
      end
    end else if (is_scc) begin
      res.dest_reg       = opcode[2:0];
      res.reg_write_kind = bcu_pkg::WK_BYTE;
      res.reg_value      = cond_ok ? bcu_pkg::SCC_SET : bcu_pkg::SCC_CLEAR;
      res.cycles         = cond_ok ? bcu_pkg::CYC_SCC_TRUE : bcu_pkg::CYC_SCC_FALSE;
    end else begin
      res.status = bcu_pkg::STATUS_UNSUP;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/branch_condition_unit.sv =====
// ----------------------------------------------------------------------------
// branch_condition_unit
// Executes BRA, BSR, Bcc, DBcc and Scc to a data register, one instruction
// per beat, through an input register and a result register.
//
//   Channel   Handshake              Payload
//   in_       in_valid / in_ready    opcode, instr_pc, ext_word, flags, count_in
//   out_      out_valid / out_ready  next_pc ... status (ten fields)
//
// One beat is accepted per cycle while in_ready is high; each beat passes the
// input register and then the result register, with decode, condition test and
// two 32-bit adds in a single pass between the two.
// Reset clears both stage valid flags; payload registers are not reset.
// While the result is stalled the input register still fills, and in_ready
// drops only when both stages hold a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module branch_condition_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_opcode,
  input  wire logic [31:0] in_instr_pc,
  input  wire logic [15:0] in_ext_word,
  input  wire logic [4:0]  in_flags,
  input  wire logic [15:0] in_count_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_next_pc,
  output logic             out_branch_taken,
  output logic             out_push_return,
  output logic [31:0]      out_return_addr,
  output logic [2:0]       out_dest_reg,
  output logic [1:0]       out_reg_write_kind,
  output logic [15:0]      out_reg_value,
  output logic [4:0]       out_cycles,
  output logic             out_uses_ext,
  output logic             out_status
);

  logic          s1_valid_r, s1_valid_nxt;
  logic [15:0]   s1_opcode_r;
  logic [31:0]   s1_pc_r;
  logic [15:0]   s1_ext_r;
  logic [3:0]    s1_nzvc_r;
  logic [15:0]   s1_count_r;
  logic          out_valid_r, out_valid_nxt;
  bcu_pkg::res_t res_r;
  bcu_pkg::res_t res_nxt;
  logic          s2_load;

  // Stage advance control.
  assign s2_load  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register; the X flag plays no part in any condition.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode_r <= in_opcode;
      s1_pc_r     <= in_instr_pc;
      s1_ext_r    <= in_ext_word;
      s1_nzvc_r   <= in_flags[3:0];
      s1_count_r  <= in_count_in;
    end
  end

  bcu_exec u_exec (
    .opcode   (s1_opcode_r),
    .instr_pc (s1_pc_r),
    .ext_word (s1_ext_r),
    .nzvc     (s1_nzvc_r),
    .count_in (s1_count_r),
    .res      (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = res_r.next_pc;
  assign out_branch_taken   = res_r.branch_taken;
  assign out_push_return    = res_r.push_return;
  assign out_return_addr    = res_r.return_addr;
  assign out_dest_reg       = res_r.dest_reg;
  assign out_reg_write_kind = res_r.reg_write_kind;
  assign out_reg_value      = res_r.reg_value;
  assign out_cycles         = res_r.cycles;
  assign out_uses_ext       = res_r.uses_ext;
  assign out_status         = res_r.status;

endmodule

`default_nettype wire

// ===== rtl/bcu_checker.sv =====
// ----------------------------------------------------------------------------
// bcu_checker
// Port-level checks on the branch condition unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "branch_condition_unit_macros.svh"

module bcu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_next_pc,
  input wire logic        out_branch_taken,
  input wire logic        out_push_return,
  input wire logic [1:0]  out_reg_write_kind,
  input wire logic [4:0]  out_cycles,
  input wire logic        out_uses_ext,
  input wire logic        out_status
);

  logic out_stall;
  logic out_unsup;
  logic out_quiet;
  logic out_bsr_ok;
  logic out_word_wr;

  // Terms the checks are built from.
  assign out_stall   = out_valid && !out_ready;
  assign out_unsup   = out_valid && (out_status == bcu_pkg::STATUS_UNSUP);
  assign out_quiet   = !out_branch_taken && !out_push_return &&
                       (out_reg_write_kind == bcu_pkg::WK_NONE) && (out_cycles == 5'd0);
  assign out_bsr_ok  = out_branch_taken && (out_cycles == bcu_pkg::CYC_BSR);
  assign out_word_wr = out_valid && (out_reg_write_kind == bcu_pkg::WK_WORD);

  // A stalled result beat stays valid and keeps its next_pc.
  `BCU_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_next_pc), "result beat changed while stalled")

  // An unsupported opcode makes no write, no branch and charges nothing.
  `BCU_ASSERT_IMPLY(a_unsup_quiet, out_unsup, out_quiet, "unsupported opcode shows activity")

  // BSR always branches and is charged CYC_BSR.
  `BCU_ASSERT_IMPLY(a_bsr_taken, out_valid && out_push_return, out_bsr_ok, "BSR result inconsistent")

  // A counter write only comes from DBcc, which always consumes the extension word.
  `BCU_ASSERT_IMPLY(a_dbcc_ext, out_word_wr, out_uses_ext, "DBcc write without extension word")

  // No result beat is shown just after reset.
  `BCU_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind branch_condition_unit bcu_checker u_bcu_checker (.*);

`default_nettype wire

// ===== sim/branch_condition_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// branch_condition_unit_checker
// Watches both channels of the branch condition unit. Every accepted
// instruction beat is decoded and executed by a local model of the BRA, BSR,
// Bcc, DBcc and Scc rules. Every accepted result beat is compared, field by
// field, with the oldest outcome still outstanding.
// ----------------------------------------------------------------------------
module branch_condition_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_instr_pc,
  input  logic [15:0] in_ext_word,
  input  logic [4:0]  in_flags,
  input  logic [15:0] in_count_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_next_pc,
  input  logic        out_branch_taken,
  input  logic        out_push_return,
  input  logic [31:0] out_return_addr,
  input  logic [2:0]  out_dest_reg,
  input  logic [1:0]  out_reg_write_kind,
  input  logic [15:0] out_reg_value,
  input  logic [4:0]  out_cycles,
  input  logic        out_uses_ext,
  input  logic        out_status,
  output int          mismatches,
  output int          outstanding
);

  // Outcomes of accepted instructions, oldest first.
  bcu_pkg::res_t outcome_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Condition test over N, Z, V and C; X plays no part.
  function automatic logic cond_holds(bcu_pkg::cond_t cc, logic [4:0] fl);
    logic c, v, z, n, hit;
    c = fl[0];
    v = fl[1];
    z = fl[2];
    n = fl[3];
    case (cc)
      bcu_pkg::COND_T:  hit = 1'b1;
      bcu_pkg::COND_F:  hit = 1'b0;
      bcu_pkg::COND_HI: hit = !c && !z;
      bcu_pkg::COND_LS: hit = c || z;
      bcu_pkg::COND_CC: hit = !c;
      bcu_pkg::COND_CS: hit = c;
      bcu_pkg::COND_NE: hit = !z;
      bcu_pkg::COND_EQ: hit = z;
      bcu_pkg::COND_VC: hit = !v;
      bcu_pkg::COND_VS: hit = v;
      bcu_pkg::COND_PL: hit = !n;
      bcu_pkg::COND_MI: hit = n;
      bcu_pkg::COND_GE: hit = (n == v);
      bcu_pkg::COND_LT: hit = (n != v);
      bcu_pkg::COND_GT: hit = !z && (n == v);
      default:          hit = z || (n != v);
    endcase
    return hit;
  endfunction

  // Executes one instruction and returns the result beat it should produce.
  function automatic bcu_pkg::res_t execute_branch(logic [15:0] op, logic [31:0] pc,
                                                   logic [15:0] ext, logic [4:0] fl,
                                                   logic [15:0] cnt);
    bcu_pkg::res_t  r;
    bcu_pkg::cond_t cc;
    logic [31:0]    disp;
    logic [31:0]    word_disp;
    logic           go;
    logic [15:0]    dec;
    r         = '0;
    r.next_pc = pc;
    cc        = bcu_pkg::cond_t'(op[11:8]);
    word_disp = {{16{ext[15]}}, ext};
    if (op[15:12] == bcu_pkg::LINE_BRANCH) begin
      // BRA, BSR and Bcc: a zero displacement byte selects the word form.
      r.uses_ext = (op[7:0] == 8'h00);
      disp = r.uses_ext ? word_disp : {{24{op[7]}}, op[7:0]};
      go = (cc == bcu_pkg::COND_T || cc == bcu_pkg::COND_F) ? 1'b1 : cond_holds(cc, fl);
      if (cc == bcu_pkg::COND_F) begin
        r.push_return = 1'b1;
        r.return_addr = pc + (r.uses_ext ? 32'd2 : 32'd0);
        r.cycles      = bcu_pkg::CYC_BSR;
      end else if (go) begin
        r.cycles = bcu_pkg::CYC_BRANCH;
      end else begin
        r.cycles = r.uses_ext ? bcu_pkg::CYC_BCC_WORD_NT : bcu_pkg::CYC_BCC_BYTE_NT;
      end
      if (go) begin
        r.branch_taken = 1'b1;
        r.next_pc      = pc + disp;
      end else begin
        r.next_pc = pc + (r.uses_ext ? 32'd2 : 32'd0);
      end
    end else if (op[15:12] == bcu_pkg::LINE_QUICK && op[7:6] == bcu_pkg::SIZE_SCC &&
                 op[5:3] == bcu_pkg::MODE_DBCC) begin
      // DBcc: a true condition falls through; otherwise the counter counts down.
      r.uses_ext = 1'b1;
      if (cond_holds(cc, fl)) begin
        r.next_pc = pc + 32'd2;
        r.cycles  = bcu_pkg::CYC_BCC_WORD_NT;
      end else begin
        dec              = cnt - 16'd1;
        r.dest_reg       = op[2:0];
        r.reg_write_kind = bcu_pkg::WK_WORD;
        r.reg_value      = dec;
        if (dec != bcu_pkg::COUNT_EXPIRED) begin
          r.branch_taken = 1'b1;
          r.next_pc      = pc + word_disp;
          r.cycles       = bcu_pkg::CYC_BRANCH;
        end else begin
          r.next_pc = pc + 32'd2;
          r.cycles  = bcu_pkg::CYC_DB_EXPIRED;
        end
      end
    end else if (op[15:12] == bcu_pkg::LINE_QUICK && op[7:6] == bcu_pkg::SIZE_SCC &&
                 op[5:3] == bcu_pkg::MODE_DREG) begin
      // Scc to a data register writes all ones or all zeros to the low byte.
      go               = cond_holds(cc, fl);
      r.dest_reg       = op[2:0];
      r.reg_write_kind = bcu_pkg::WK_BYTE;
      r.reg_value      = go ? bcu_pkg::SCC_SET : bcu_pkg::SCC_CLEAR;
      r.cycles         = go ? bcu_pkg::CYC_SCC_TRUE : bcu_pkg::CYC_SCC_FALSE;
    end else begin
      r.status = bcu_pkg::STATUS_UNSUP;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result beats are checked before the same edge's instruction beat is queued.
  always @(posedge clk) begin
    bcu_pkg::res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result beat arrived with no instruction outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("next_pc", want.next_pc, out_next_pc);
          check_field("branch_taken", 32'(want.branch_taken), 32'(out_branch_taken));
          check_field("push_return", 32'(want.push_return), 32'(out_push_return));
          check_field("return_addr", want.return_addr, out_return_addr);
          check_field("dest_reg", 32'(want.dest_reg), 32'(out_dest_reg));
          check_field("reg_write_kind", 32'(want.reg_write_kind),
                      32'(out_reg_write_kind));
          check_field("reg_value", 32'(want.reg_value), 32'(out_reg_value));
          check_field("cycles", 32'(want.cycles), 32'(out_cycles));
          check_field("uses_ext", 32'(want.uses_ext), 32'(out_uses_ext));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        outcome_q.push_back(execute_branch(in_opcode, in_instr_pc, in_ext_word,
                                           in_flags, in_count_in));
      end
    end
    outstanding <= outcome_q.size();
  end

endmodule

// ===== sim/branch_condition_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// branch_condition_unit_tb
// Drives instruction beats into the branch condition unit: a directed set of
// branch, loop and set instructions at their corner values, then random
// instruction mixes under three idling patterns on the two channels. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module branch_condition_unit_tb;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [15:0] in_opcode   = '0;
  logic [31:0] in_instr_pc = '0;
  logic [15:0] in_ext_word = '0;
  logic [4:0]  in_flags    = '0;
  logic [15:0] in_count_in = '0;
  logic        out_ready   = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_next_pc;
  logic        out_branch_taken;
  logic        out_push_return;
  logic [31:0] out_return_addr;
  logic [2:0]  out_dest_reg;
  logic [1:0]  out_reg_write_kind;
  logic [15:0] out_reg_value;
  logic [4:0]  out_cycles;
  logic        out_uses_ext;
  logic        out_status;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  always #5 clk = ~clk;

  branch_condition_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_instr_pc        (in_instr_pc),
    .in_ext_word        (in_ext_word),
    .in_flags           (in_flags),
    .in_count_in        (in_count_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_pc        (out_next_pc),
    .out_branch_taken   (out_branch_taken),
    .out_push_return    (out_push_return),
    .out_return_addr    (out_return_addr),
    .out_dest_reg       (out_dest_reg),
    .out_reg_write_kind (out_reg_write_kind),
    .out_reg_value      (out_reg_value),
    .out_cycles         (out_cycles),
    .out_uses_ext       (out_uses_ext),
    .out_status         (out_status)
  );

  branch_condition_unit_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_instr_pc        (in_instr_pc),
    .in_ext_word        (in_ext_word),
    .in_flags           (in_flags),
    .in_count_in        (in_count_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_pc        (out_next_pc),
    .out_branch_taken   (out_branch_taken),
    .out_push_return    (out_push_return),
    .out_return_addr    (out_return_addr),
    .out_dest_reg       (out_dest_reg),
    .out_reg_write_kind (out_reg_write_kind),
    .out_reg_value      (out_reg_value),
    .out_cycles         (out_cycles),
    .out_uses_ext       (out_uses_ext),
    .out_status         (out_status),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // Result side: stall at random at the current idling rate.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Offers one instruction beat after a random gap and holds it until accepted.
  task automatic send_instr(logic [15:0] op, logic [31:0] pc, logic [15:0] ext,
                            logic [4:0] fl, logic [15:0] cnt);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_instr_pc <= pc;
    in_ext_word <= ext;
    in_flags    <= fl;
    in_count_in <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Random instructions, weighted towards well-formed branch, loop and set forms.
  task automatic random_burst(int count);
    logic [15:0] op;
    logic [31:0] pc;
    logic [15:0] ext;
    logic [15:0] cnt;
    logic [7:0]  d8;
    logic [3:0]  cc;
    logic [2:0]  dn;
    int          pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      cc   = 4'($urandom);
      dn   = 3'($urandom);
      d8   = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
      if (pick < 35) begin
        op = {bcu_pkg::LINE_BRANCH, cc, d8};
      end else if (pick < 60) begin
        op = {bcu_pkg::LINE_QUICK, cc, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DBCC, dn};
      end else if (pick < 80) begin
        op = {bcu_pkg::LINE_QUICK, cc, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DREG, dn};
      end else begin
        op = 16'($urandom);
      end
      // Address corners exercise wrap-around of the target and return address.
      case ($urandom_range(0, 9))
        0:       pc = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
        1:       pc = 32'($urandom_range(0, 15));
        default: pc = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       ext = 16'h8000;
        1:       ext = 16'h7FFF;
        2:       ext = 16'h0000;
        default: ext = 16'($urandom);
      endcase
      // A counter of zero makes the loop expire; one leaves it at zero.
      case ($urandom_range(0, 9))
        0:       cnt = 16'h0000;
        1:       cnt = 16'h0001;
        2:       cnt = 16'hFFFF;
        default: cnt = 16'($urandom);
      endcase
      send_instr(op, pc, ext, 5'($urandom), cnt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: sender idles often, receiver stalls more.
    set_idling(29, 47);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_T, 8'h10}, 32'h0000_1000, 16'h1234,
               5'h00, 16'h0000);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_T, 8'hFF}, 32'h0000_2000, 16'hFFFF,
               5'h1F, 16'hFFFF);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_T, 8'h80}, 32'h0000_0010, 16'h0000,
               5'h00, 16'h0000);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_T, 8'h00}, 32'h0000_0000, 16'h8000,
               5'h1F, 16'h0001);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_T, 8'h00}, 32'hFFFF_FFFF, 16'h7FFF,
               5'h00, 16'h8000);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_F, 8'h10}, 32'hFFFF_FFF8, 16'h0000,
               5'h0A, 16'h0000);
    send_instr({bcu_pkg::LINE_BRANCH, bcu_pkg::COND_F, 8'h00}, 32'hFFFF_FFFE, 16'hFFFE,
               5'h15, 16'h0000);
    // Every proper condition once, word and byte forms alternating.
    for (int i = bcu_pkg::COND_HI; i <= bcu_pkg::COND_LE; i++) begin
      send_instr({bcu_pkg::LINE_BRANCH, 4'(i), (i % 2 == 0) ? 8'h00 : 8'h7E},
                 $urandom, 16'($urandom), 5'($urandom), 16'($urandom));
    end
    // Loop: condition true, counter expiring, counter still running.
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_T, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DBCC,
                3'd0}, 32'h4000, 16'hFFF0, 5'h00, 16'h0005);
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_F, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DBCC,
                3'd7}, 32'h4000, 16'hFFF0, 5'h1F, 16'h0000);
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_F, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DBCC,
                3'd3}, 32'h4000, 16'hFFF0, 5'h00, 16'h0005);
    // Set on condition, true and false.
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_T, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DREG,
                3'd7}, 32'h5000, 16'h0000, 5'h00, 16'h0000);
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_F, bcu_pkg::SIZE_SCC, bcu_pkg::MODE_DREG,
                3'd0}, 32'h5000, 16'h0000, 5'h1F, 16'h0000);
    // Opcodes outside the unit: Scc to memory, ADDQ and a return.
    send_instr({bcu_pkg::LINE_QUICK, bcu_pkg::COND_T, bcu_pkg::SIZE_SCC, 3'd2, 3'd0},
               32'h6000, 16'h0000, 5'h00, 16'h0);
    send_instr({bcu_pkg::LINE_QUICK, 4'h0, 2'b01, bcu_pkg::MODE_DBCC, 3'd0},
               32'h6000, 16'h0000, 5'h00, 16'h0);
    send_instr(16'h4E75, 32'h6000, 16'h0000, 5'h00, 16'h0000);

    random_burst(640);
    drain_results();

    set_idling(47, 29);
    random_burst(650);
    drain_results();

    set_idling(0, 0);
    random_burst(650);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bcu_pkg.sv
rtl/bcu_cond.sv
rtl/bcu_exec.sv
rtl/branch_condition_unit.sv
rtl/bcu_checker.sv
sim/branch_condition_unit_checker.sv
sim/branch_condition_unit_tb.sv
